>>> hdl/lts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stop-and-wait sender package
// Shared types, codes and window constants of the loss-tolerant sender.
// ----------------------------------------------------------------------------
package lts_pkg;

	localparam int WIN_SIZE   = 100;
	localparam int HEAD_W     = $clog2(WIN_SIZE);
	localparam int CNT_W      = 7;
	localparam int PROD_W     = 2 * CNT_W;
	localparam int LIMIT_W    = 7;
	localparam int LOSS_SCALE = 100;

	// Request modes.
	localparam logic [1:0] MODE_SEND    = 2'd0;
	localparam logic [1:0] MODE_ACK     = 2'd1;
	localparam logic [1:0] MODE_TIMEOUT = 2'd2;

	// Result actions.
	localparam logic [2:0] ACT_TRANSMIT   = 3'd0;
	localparam logic [2:0] ACT_RETRANSMIT = 3'd1;
	localparam logic [2:0] ACT_DELIVERED  = 3'd2;
	localparam logic [2:0] ACT_LOSS_OK    = 3'd3;
	localparam logic [2:0] ACT_IGNORED    = 3'd4;

	typedef struct packed {
		logic [1:0] mode;
		logic       ack_bit;
	} req_t;

	typedef struct packed {
		logic [2:0]       action;
		logic             seq_bit;
		logic [CNT_W-1:0] losses_in_window;
		logic [CNT_W-1:0] outcomes_in_window;
	} rsp_t;

	// Decision for one request, passed from the decision logic to the top level.
	typedef struct packed {
		logic       rec;
		logic       lost;
		logic       pend_set;
		logic       pend_clr;
		logic       flip;
		logic [2:0] action;
	} dec_t;

	// Window counters as seen by the decision logic.
	typedef struct packed {
		logic [CNT_W-1:0] losses;
		logic [CNT_W-1:0] outcomes;
	} win_cnt_t;

endpackage

>>> hdl/lts_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Outcome window
// Ring of recent outcomes with its head pointer and loss and outcome counters.
// ----------------------------------------------------------------------------
module lts_window (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rec,
	input  logic                     lost,
	output lts_pkg::win_cnt_t        cur,
	output lts_pkg::win_cnt_t        nxt
);

	logic                           ring_q [lts_pkg::WIN_SIZE];
	logic                           old_q;
	logic [lts_pkg::HEAD_W-1:0]     head_q;
	logic [lts_pkg::HEAD_W-1:0]     head_nxt;
	logic [lts_pkg::HEAD_W-1:0]     rd_addr;
	logic [lts_pkg::CNT_W-1:0]      loss_q;
	logic [lts_pkg::CNT_W-1:0]      cnt_q;
	logic [lts_pkg::CNT_W-1:0]      loss_nxt;
	logic [lts_pkg::CNT_W-1:0]      cnt_nxt;
	logic                           full;
	logic                           dec_loss;

	assign full = (cnt_q == lts_pkg::CNT_W'(lts_pkg::WIN_SIZE));
	assign head_nxt = (head_q == lts_pkg::HEAD_W'(lts_pkg::WIN_SIZE - 1)) ?
		'0 : head_q + lts_pkg::HEAD_W'(1);

	// old_q always holds the ring entry under the head, so the overwritten
	// outcome is known without a read in the same cycle.
	assign dec_loss = rec && full && old_q && (loss_q != '0);

	always_comb begin
		loss_nxt = loss_q;
		cnt_nxt  = cnt_q;
		if (rec) begin
			loss_nxt = loss_q - lts_pkg::CNT_W'(dec_loss) + lts_pkg::CNT_W'(lost);
			if (!full) begin
				cnt_nxt = cnt_q + lts_pkg::CNT_W'(1);
			end
		end
	end

	assign rd_addr = rec ? head_nxt : head_q;

	assign cur.losses   = loss_q;
	assign cur.outcomes = cnt_q;
	assign nxt.losses   = loss_nxt;
	assign nxt.outcomes = cnt_nxt;

	always_ff @(posedge clk) begin
		if (rec) begin
			ring_q[head_q] <= lost;
		end
		if (rec && (rd_addr == head_q)) begin
			old_q <= lost;
		end else begin
			old_q <= ring_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			loss_q <= '0;
			cnt_q  <= '0;
		end else if (rec) begin
			head_q <= head_nxt;
			loss_q <= loss_nxt;
			cnt_q  <= cnt_nxt;
		end
	end

endmodule

>>> hdl/lts_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request decision
// Chooses the action for one request from the protocol state and the window.
// ----------------------------------------------------------------------------
module lts_decide (
	input  lts_pkg::req_t                req,
	input  logic                         seq,
	input  logic                         pending,
	input  logic [lts_pkg::LIMIT_W-1:0]  limit,
	input  lts_pkg::win_cnt_t            win,
	output lts_pkg::dec_t                dec
);

	logic [lts_pkg::PROD_W-1:0] loss_scaled;
	logic [lts_pkg::PROD_W-1:0] limit_scaled;
	logic                       loss_ok;
	logic                       ack_match;

	assign loss_scaled  = lts_pkg::PROD_W'(lts_pkg::LOSS_SCALE) *
		lts_pkg::PROD_W'(win.losses);
	assign limit_scaled = lts_pkg::PROD_W'(limit) * lts_pkg::PROD_W'(win.outcomes);
	assign loss_ok      = (win.outcomes == '0) || (loss_scaled < limit_scaled);
	assign ack_match    = (req.mode == lts_pkg::MODE_ACK) && (req.ack_bit == seq);

	always_comb begin
		dec = '0;
		dec.action = lts_pkg::ACT_IGNORED;
		case (req.mode)
			lts_pkg::MODE_SEND: begin
				dec.action   = lts_pkg::ACT_TRANSMIT;
				dec.pend_set = 1'b1;
			end
			lts_pkg::MODE_ACK, lts_pkg::MODE_TIMEOUT: begin
				if (pending) begin
					if (ack_match) begin
						dec.action   = lts_pkg::ACT_DELIVERED;
						dec.rec      = 1'b1;
						dec.flip     = 1'b1;
						dec.pend_clr = 1'b1;
					end else if (loss_ok) begin
						dec.action   = lts_pkg::ACT_LOSS_OK;
						dec.rec      = 1'b1;
						dec.lost     = 1'b1;
						dec.pend_clr = 1'b1;
					end else begin
						dec.action = lts_pkg::ACT_RETRANSMIT;
					end
				end
			end
			default: begin
				dec.action = lts_pkg::ACT_IGNORED;
			end
		endcase
	end

endmodule

>>> hdl/loss_tolerant_stop_and_wait_sender_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loss-tolerant stop-and-wait sender
// Alternating-bit sender that accepts a loss while the windowed loss rate
// stays below a programmable limit, and orders a retransmit otherwise.
// ----------------------------------------------------------------------------
//  Channel  Signals                         Content
//  req      req_valid, req_ready, req       send request, ack or timeout
//  rsp      rsp_valid, rsp_ready, rsp       action, sequence bit, window counts
//  cfg      cfg_valid, cfg_ready, cfg_data  tolerated loss percentage
//
//  One request per cycle is sustained while the sink takes every result; each
//  request passes the input register and then the result register.
//  While a result waits for the sink, the input register takes one more request
//  and then stalls the request channel.
//  The window ring is a 100 x 1 memory whose next head entry is prefetched.
//  Reset clears the counters, sequence bit, pending flag and loss limit.
//  Configuration writes are always ready; the loss limit is registered.
// ----------------------------------------------------------------------------
module loss_tolerant_stop_and_wait_sender_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  lts_pkg::req_t                req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output lts_pkg::rsp_t                rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lts_pkg::LIMIT_W-1:0]  cfg_data
);

	lts_pkg::req_t               req_s1;
	logic                        valid_s1;
	lts_pkg::rsp_t               rsp_q;
	logic                        rsp_valid_q;
	logic [lts_pkg::LIMIT_W-1:0] limit_q;
	logic                        seq_q;
	logic                        pending_q;
	logic                        advance;
	lts_pkg::dec_t               dec;
	lts_pkg::win_cnt_t           win_cur;
	lts_pkg::win_cnt_t           win_nxt;
	logic                        seq_nxt;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	lts_decide u_decide (
		.req     (req_s1),
		.seq     (seq_q),
		.pending (pending_q),
		.limit   (limit_q),
		.win     (win_cur),
		.dec     (dec)
	);

	lts_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.rec    (advance && dec.rec),
		.lost   (dec.lost),
		.cur    (win_cur),
		.nxt    (win_nxt)
	);

	assign seq_nxt = dec.flip ? ~seq_q : seq_q;

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q.action             <= dec.action;
			rsp_q.seq_bit            <= seq_nxt;
			rsp_q.losses_in_window   <= win_nxt.losses;
			rsp_q.outcomes_in_window <= win_nxt.outcomes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			limit_q     <= '0;
			seq_q       <= 1'b0;
			pending_q   <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (advance) begin
				seq_q <= seq_nxt;
				if (dec.pend_set) begin
					pending_q <= 1'b1;
				end else if (dec.pend_clr) begin
					pending_q <= 1'b0;
				end
			end
		end
	end

endmodule
